[hdl/kts_pkg.sv]
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants for the key/tag insertion sorter.
// ----------------------------------------------------------------------------
package kts_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int KEY_W       = 63;
	localparam int TAG_W       = 8;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_READ     = 2'd2,
		ST_EMPTY    = 2'd3
	} kts_status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} kts_entry_t;

	typedef struct packed {
		logic             req_type;
		logic [KEY_W-1:0] size;
		logic [TAG_W-1:0] tag;
	} kts_cmd_t;

	typedef struct packed {
		kts_status_t      status;
		logic [KEY_W-1:0] size;
		logic [TAG_W-1:0] tag;
		logic             last;
	} kts_res_t;

endpackage

[hdl/kts_engine.sv]
// ----------------------------------------------------------------------------
// kts_engine
// Sorted entry memory with a sequencer that walks an insert down from the top,
// one key compare at a time, and serves in-order reads.
// ----------------------------------------------------------------------------
module kts_engine
	import kts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  kts_cmd_t cmd,
	output logic     idle,
	output logic     res_valid,
	input  logic     res_ready,
	output kts_res_t res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_RD_WAIT,
		S_DONE
	} state_t;

	state_t             state_q;
	kts_cmd_t           cmd_q;
	logic [ADDR_W-1:0]  pos_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_pos_q;
	kts_res_t           res_q;

	kts_entry_t         mem [MAX_ENTRIES];
	kts_entry_t         rdata_q;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	kts_entry_t         mem_wdata;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;

	logic               greater;
	logic               rd_avail;
	logic               rd_last;
	kts_entry_t         new_entry;

	assign new_entry = '{key: cmd_q.size, tag: cmd_q.tag};
	// the one shared compare: stored key against the key being inserted
	assign greater   = rdata_q.key > cmd_q.size;
	assign rd_avail  = rd_pos_q < count_q;
	assign rd_last   = CNT_W'(rd_pos_q + 1'b1) == count_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = new_entry;
		mem_re    = 1'b0;
		mem_raddr = pos_q - 1'b1;
		case (state_q)
			S_IDLE: begin
				if (start && cmd.req_type == REQ_READ && rd_avail) begin
					mem_re    = 1'b1;
					mem_raddr = rd_pos_q[ADDR_W-1:0];
				end
			end
			S_INS_RD: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_INS_CMP: begin
				// shift the greater entry up one place, or drop the new pair in
				mem_we = 1'b1;
				if (greater) begin
					mem_wdata = rdata_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_pos_q <= '0;
			pos_q    <= '0;
			cmd_q    <= '0;
			res_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						if (cmd.req_type == REQ_READ) begin
							if (rd_avail) begin
								state_q <= S_RD_WAIT;
							end else begin
								res_q   <= '{status: ST_EMPTY, size: '0, tag: '0,
									last: 1'b0};
								state_q <= S_DONE;
							end
						end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
							res_q   <= '{status: ST_FULL, size: '0, tag: '0, last: 1'b0};
							state_q <= S_DONE;
						end else begin
							pos_q   <= count_q[ADDR_W-1:0];
							state_q <= S_INS_RD;
						end
					end
				end
				S_INS_RD: begin
					if (pos_q == '0) begin
						count_q <= count_q + 1'b1;
						res_q   <= '{status: ST_INSERTED, size: '0, tag: '0, last: 1'b0};
						state_q <= S_DONE;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (greater) begin
						pos_q   <= pos_q - 1'b1;
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + 1'b1;
						res_q   <= '{status: ST_INSERTED, size: '0, tag: '0, last: 1'b0};
						state_q <= S_DONE;
					end
				end
				S_RD_WAIT: begin
					res_q <= '{status: ST_READ, size: rdata_q.key, tag: rdata_q.tag,
						last: rd_last};
					// empty the store once its last entry goes out
					if (rd_last) begin
						count_q  <= '0;
						rd_pos_q <= '0;
					end else begin
						rd_pos_q <= rd_pos_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;

endmodule

[hdl/key_tag_insertion_sorter.sv]
// ----------------------------------------------------------------------------
// key_tag_insertion_sorter
// Stable sorted store of (size key, name tag) pairs with in-order readout.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  input   | in_valid / in_ready   | req_type, entry_size, name_tag
//  output  | out_valid / out_ready | status, out_size, out_tag, last_of_run
//
// A read passes through S_RD_WAIT to S_DONE, and a full insert or an empty read
// goes straight to S_DONE. An insert steps through S_INS_RD and S_INS_CMP once
// for each stored key greater than the new one, then writes the new pair. The
// insert walk is set by the single-port entry memory: one read and one compare
// per shifted entry. in_ready is low while an item is in work and while its
// result waits for the full output register. Reset empties the store; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module key_tag_insertion_sorter
	import kts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  logic [KEY_W-1:0] entry_size,
	input  logic [TAG_W-1:0] name_tag,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [KEY_W-1:0] out_size,
	output logic [TAG_W-1:0] out_tag,
	output logic             last_of_run
);

	logic     eng_idle;
	logic     eng_res_valid;
	logic     eng_res_ready;
	kts_res_t eng_res;
	kts_cmd_t cmd;

	logic     out_valid_q;
	kts_res_t out_q;

	assign cmd = '{req_type: req_type, size: entry_size, tag: name_tag};

	kts_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.cmd       (cmd),
		.idle      (eng_idle),
		.res_valid (eng_res_valid),
		.res_ready (eng_res_ready),
		.res       (eng_res)
	);

	assign in_ready      = eng_idle;
	// load the output register when it is empty or being drained
	assign eng_res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_res_valid && eng_res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid && eng_res_ready) begin
			out_q <= eng_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign out_size    = out_q.size;
	assign out_tag     = out_q.tag;
	assign last_of_run = out_q.last;

endmodule

[dv/key_tag_insertion_sorter_tb.sv]
// ----------------------------------------------------------------------------
// key_tag_insertion_sorter_tb
// Drives insert and read transactions into the sorter with random gaps and
// output back-pressure, and checks every result against a shadow sorted store.
// A short table of hand-picked transactions comes first (ties, extreme keys,
// inserts in the middle of a read run, empty reads). Random sorted runs,
// noise and one full-store fill follow.
// ----------------------------------------------------------------------------
module key_tag_insertion_sorter_tb;
	import kts_pkg::*;

	localparam int                RANDOM_ITEMS = 1400;
	localparam int                LONG_HOLD    = 300;
	localparam logic [KEY_W-1:0]  KEY_MAX      = '1;

	typedef struct {
		logic             rq;
		logic [KEY_W-1:0] size;
		logic [TAG_W-1:0] tag;
		bit               typed;
		kts_status_t      typed_status;
	} dir_row_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	logic             req_type    = 1'b0;
	logic [KEY_W-1:0] entry_size  = '0;
	logic [TAG_W-1:0] name_tag    = '0;
	logic             out_valid;
	logic             out_ready   = 1'b0;
	logic [1:0]       status;
	logic [KEY_W-1:0] out_size;
	logic [TAG_W-1:0] out_tag;
	logic             last_of_run;

	// shadow copy of the sorted store
	logic [KEY_W-1:0] shadow_keys [MAX_ENTRIES];
	logic [TAG_W-1:0] shadow_tags [MAX_ENTRIES];
	int               shadow_count = 0;
	int               shadow_rdpos = 0;

	kts_res_t         pending_results [$];
	dir_row_t         dir_rows [$];
	int               items_sent     = 0;
	int               mismatch_count = 0;
	bit               no_gaps        = 1'b0;
	bit               hold_request   = 1'b0;

	key_tag_insertion_sorter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.entry_size  (entry_size),
		.name_tag    (name_tag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_size    (out_size),
		.out_tag     (out_tag),
		.last_of_run (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one transaction to the shadow store and return the result it yields.
	function automatic kts_res_t predict_sorted_result(input logic rq,
			input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t);
		kts_res_t r;
		int       pos;
		r = '0;
		if (rq == REQ_INSERT) begin
			if (shadow_count >= MAX_ENTRIES) begin
				r.status = ST_FULL;
			end else begin
				// shift strictly greater keys up so ties keep arrival order
				pos = shadow_count;
				while (pos > 0 && shadow_keys[pos-1] > k) begin
					shadow_keys[pos] = shadow_keys[pos-1];
					shadow_tags[pos] = shadow_tags[pos-1];
					pos--;
				end
				shadow_keys[pos] = k;
				shadow_tags[pos] = t;
				shadow_count++;
				r.status = ST_INSERTED;
			end
		end else if (shadow_rdpos >= shadow_count) begin
			r.status = ST_EMPTY;
		end else begin
			r.status = ST_READ;
			r.size   = shadow_keys[shadow_rdpos];
			r.tag    = shadow_tags[shadow_rdpos];
			r.last   = (shadow_rdpos + 1 >= shadow_count);
			if (r.last) begin
				shadow_count = 0;
				shadow_rdpos = 0;
			end else begin
				shadow_rdpos++;
			end
		end
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		k = KEY_W'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: k = KEY_W'($urandom_range(0, 15));
			5: k = '0;
			6: k = KEY_MAX;
			7: k = KEY_MAX - KEY_W'($urandom_range(0, 15));
			default: ;
		endcase
		return k;
	endfunction

	function automatic logic [TAG_W-1:0] rand_tag();
		return TAG_W'($urandom);
	endfunction

	function automatic void add_row(input logic rq, input logic [KEY_W-1:0] k,
			input logic [TAG_W-1:0] t, input bit typed, input kts_status_t st);
		dir_row_t row;
		row.rq           = rq;
		row.size         = k;
		row.tag          = t;
		row.typed        = typed;
		row.typed_status = st;
		dir_rows.push_back(row);
	endfunction

	// Offer one transaction and hold it until accepted.
	task automatic send_item(input logic rq, input logic [KEY_W-1:0] k,
			input logic [TAG_W-1:0] t, input bit typed, input kts_status_t typed_st);
		int       gap;
		kts_res_t r;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= rq;
		entry_size <= k;
		name_tag   <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_sorted_result(rq, k, t);
		if (typed) begin
			r        = '0;
			r.status = typed_st;
		end
		pending_results.push_back(r);
		items_sent++;
	endtask

	task automatic read_item();
		send_item(REQ_READ, rand_key(), rand_tag(), 1'b0, ST_READ);
	endtask

	// Insert a batch, then read it out; now and then insert in the middle of the read run.
	task automatic sorted_run(input int n);
		repeat (n) send_item(REQ_INSERT, rand_key(), rand_tag(), 1'b0, ST_INSERTED);
		while (shadow_count != 0) begin
			if ($urandom_range(0, 6) == 0)
				send_item(REQ_INSERT, rand_key(), rand_tag(), 1'b0, ST_INSERTED);
			else
				read_item();
		end
		if ($urandom_range(0, 2) == 0)
			read_item();
	endtask

	// Fill the store past capacity, then drain it.
	task automatic fill_store();
		logic [KEY_W-1:0] k;
		k = '0;
		while (shadow_count != 0) read_item();
		for (int i = 0; i < MAX_ENTRIES + 3; i++) begin
			if (i >= MAX_ENTRIES - 6)
				k = rand_key();
			else if ($urandom_range(0, 3) != 0)
				k = k + KEY_W'($urandom_range(1, 1000));
			send_item(REQ_INSERT, k, rand_tag(), 1'b0, ST_INSERTED);
		end
		while (shadow_count != 0) read_item();
		read_item();
	endtask

	task automatic check_result();
		kts_res_t exp_r;
		if (pending_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected result: status=%0d size=%0h tag=%0h last=%0b",
					status, out_size, out_tag, last_of_run);
			return;
		end
		exp_r = pending_results.pop_front();
		if (status !== exp_r.status || out_size !== exp_r.size ||
				out_tag !== exp_r.tag || last_of_run !== exp_r.last) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch: expected status=%0d size=%0h tag=%0h last=%0b, %s",
					exp_r.status, exp_r.size, exp_r.tag, exp_r.last,
					$sformatf("got status=%0d size=%0h tag=%0h last=%0b",
						status, out_size, out_tag, last_of_run));
		end
	endtask

	initial begin : result_sink
		int wait_cycles;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				wait_cycles  = LONG_HOLD;
			end else begin
				wait_cycles = no_gaps ? 0 : $urandom_range(0, 9);
			end
			if (wait_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			check_result();
		end
	end

	initial begin : stimulus
		bit filled;
		bit held;
		filled = 1'b0;
		held   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rq, key, tag, typed, typed status
		add_row(REQ_READ,   KEY_MAX,   8'hFF, 1'b1, ST_EMPTY);
		add_row(REQ_INSERT, KEY_MAX,   8'hFF, 1'b1, ST_INSERTED);
		add_row(REQ_INSERT, '0,        8'h00, 1'b1, ST_INSERTED);
		add_row(REQ_INSERT, 63'd5,     8'h01, 1'b1, ST_INSERTED);
		add_row(REQ_INSERT, 63'd5,     8'h02, 1'b1, ST_INSERTED);
		add_row(REQ_INSERT, 63'd5,     8'h03, 1'b1, ST_INSERTED);
		add_row(REQ_READ,   KEY_MAX,   8'hFF, 1'b0, ST_READ);
		add_row(REQ_READ,   '0,        8'h00, 1'b0, ST_READ);
		// lands below the read index: the entry just read shifts to the index and comes back again
		add_row(REQ_INSERT, 63'd1,     8'h10, 1'b0, ST_INSERTED);
		add_row(REQ_READ,   KEY_MAX,   8'hAA, 1'b0, ST_READ);
		add_row(REQ_INSERT, KEY_MAX,   8'h11, 1'b0, ST_INSERTED);
		add_row(REQ_READ,   63'd7,     8'h55, 1'b0, ST_READ);
		add_row(REQ_READ,   '0,        8'hFF, 1'b0, ST_READ);
		add_row(REQ_READ,   KEY_MAX,   8'h00, 1'b0, ST_READ);
		add_row(REQ_READ,   63'd3,     8'h80, 1'b0, ST_READ);
		add_row(REQ_READ,   KEY_MAX,   8'hFF, 1'b1, ST_EMPTY);
		add_row(REQ_INSERT, 63'd42,    8'h7E, 1'b1, ST_INSERTED);
		add_row(REQ_READ,   '0,        8'h00, 1'b0, ST_READ);
		add_row(REQ_READ,   '0,        8'h00, 1'b1, ST_EMPTY);
		foreach (dir_rows[i])
			send_item(dir_rows[i].rq, dir_rows[i].size, dir_rows[i].tag,
				dir_rows[i].typed, dir_rows[i].typed_status);

		while (items_sent < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if (!filled && items_sent >= 300) begin
				filled = 1'b1;
				fill_store();
			end else if (!held && items_sent >= 900) begin
				// stall the output while inputs keep coming back to back
				held         = 1'b1;
				no_gaps      = 1'b1;
				hold_request = 1'b1;
				sorted_run(24);
			end else if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6))
					send_item(($urandom_range(0, 1) == 1) ? REQ_READ : REQ_INSERT,
						rand_key(), rand_tag(), 1'b0, ST_READ);
			end else begin
				sorted_run($urandom_range(1, 24));
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#40_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
